@@ hw/rtl/fpfa_pkg.sv @@
// Shared constants and types for the fixed partition fit allocator.
`default_nettype none

package fpfa_pkg;

    // Default sizing
    localparam int NUM_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Fit modes
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    // Commands (travel on s_tuser)
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_IN_USE   = 1'b1;

    // Reset values of the registers
    localparam logic [1:0] FIT_MODE_RST = MODE_FIRST;
    localparam logic [4:0] IN_USE_RST   = 5'd16;

    // Field widths
    localparam int PIDX_W   = 4;
    localparam int AMT_W    = 16;
    localparam int REQNUM_W = 16;
    localparam int INUSE_W  = 5;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // Control part of the search word that moves down the cell row
    typedef struct packed {
        logic       valid;
        logic       found;
        logic [1:0] mode;
    } tok_ctl_t;

endpackage : fpfa_pkg

`default_nettype wire

@@ hw/rtl/fpfa_cell.sv @@
// One partition cell: holds capacity and used amount, and refines the search word.
`default_nettype none

module fpfa_cell #(
    parameter int IDX       = 0,
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  [fpfa_pkg::INUSE_W-1:0] limit,
    // load broadcast
    input  wire                         ld_en,
    input  wire  [fpfa_pkg::PIDX_W-1:0] ld_idx,
    input  wire  [SIZE_BITS-1:0]        ld_amt,
    // commit broadcast
    input  wire                         cm_en,
    input  wire  [IDX_W-1:0]            cm_sel,
    input  wire  [SIZE_BITS-1:0]        cm_amt,
    // search word in
    input  fpfa_pkg::tok_ctl_t          ctl_in,
    input  wire  [SIZE_BITS-1:0]        amt_in,
    input  wire  [IDX_W-1:0]            sel_in,
    input  wire  [SIZE_BITS-1:0]        free_in,
    input  wire  [SIZE_BITS-1:0]        cap_in,
    // search word out (registered)
    output fpfa_pkg::tok_ctl_t          ctl_out,
    output logic [SIZE_BITS-1:0]        amt_out,
    output logic [IDX_W-1:0]            sel_out,
    output logic [SIZE_BITS-1:0]        free_out,
    output logic [SIZE_BITS-1:0]        cap_out
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0] cap_reg;
    logic [SIZE_BITS-1:0] used_reg;
    logic [SIZE_BITS-1:0] free_space;
    logic                 in_use;
    logic                 fits;
    logic                 take;
    tok_ctl_t             ctl_reg;
    logic [SIZE_BITS-1:0] amt_reg;
    logic [IDX_W-1:0]     sel_reg;
    logic [SIZE_BITS-1:0] free_reg;
    logic [SIZE_BITS-1:0] cap_o_reg;

    // free space and fit decision
    always_comb
    begin
        free_space = (used_reg > cap_reg) ? '0 : (cap_reg - used_reg);
        in_use     = (32'(IDX) < 32'(limit));
        fits       = ctl_in.valid && in_use && (free_space >= amt_in);
        take       = 1'b0;
        case (ctl_in.mode)
            MODE_FIRST: take = fits && !ctl_in.found;
            MODE_BEST:  take = fits && (!ctl_in.found || (free_space < free_in));
            MODE_WORST: take = fits && (!ctl_in.found || (free_space > free_in));
            default:    take = 1'b0;
        endcase
    end

    // partition state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= '0;
            used_reg <= '0;
        end
        else if (ld_en && (32'(ld_idx) == 32'(IDX)))
        begin
            cap_reg  <= ld_amt;
            used_reg <= '0;
        end
        else if (cm_en && (32'(cm_sel) == 32'(IDX)))
        begin
            used_reg <= used_reg + cm_amt;
        end
    end

    // search word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg.valid <= ctl_in.valid;
            ctl_reg.found <= ctl_in.found || take;
            ctl_reg.mode  <= ctl_in.mode;
        end
    end

    // search word data
    always_ff @(posedge clk)
    begin
        amt_reg   <= amt_in;
        sel_reg   <= take ? IDX_W'(IDX) : sel_in;
        free_reg  <= take ? free_space  : free_in;
        cap_o_reg <= take ? cap_reg     : cap_in;
    end

    assign ctl_out  = ctl_reg;
    assign amt_out  = amt_reg;
    assign sel_out  = sel_reg;
    assign free_out = free_reg;
    assign cap_out  = cap_o_reg;

endmodule : fpfa_cell

`default_nettype wire

@@ hw/rtl/fixed_partition_fit_allocator.sv @@
// Top level: control, configuration registers and the row of partition cells.
// A load word gives no result; the next word can be taken the cycle after.
// A request word walks the cell row one cell a cycle, is held in a pending register and
// then goes to the output register; no new word is taken until it has been committed to
// the output register. A held output stalls the next request until taken.
// Reset (rst_n, async, active low) clears all capacities, used amounts and the request count.
`default_nettype none

module fixed_partition_fit_allocator #(
    parameter int NUM_PARTITIONS = fpfa_pkg::NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = fpfa_pkg::SIZE_BITS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // input words
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [fpfa_pkg::S_DATA_W-1:0] s_tdata,  // partition_index[3:0], amount[19:4]
    input  wire  [0:0]                    s_tuser,  // command[0]
    // result words
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [fpfa_pkg::M_DATA_W-1:0] m_tdata,  // request_number[15:0], placed[16],
                                                    // chosen_partition[20:17],
                                                    // chosen_capacity[36:21]
    // configuration
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [2:0]                    paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fpfa_pkg::*;

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [1:0]            fit_mode_reg;
    logic [INUSE_W-1:0]    in_use_reg;
    logic [REQNUM_W-1:0]   req_cnt_reg;
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic                  pend_found_reg;
    logic [IDX_W-1:0]      pend_sel_reg;
    logic [SIZE_BITS-1:0]  pend_amt_reg;
    logic [SIZE_BITS-1:0]  pend_cap_reg;

    logic                  cfg_wr;
    logic                  accept;
    logic                  ld_en;
    logic                  commit;
    logic [SIZE_BITS-1:0]  in_amt;

    tok_ctl_t              ctl_chain  [0:NUM_PARTITIONS];
    logic [SIZE_BITS-1:0]  amt_chain  [0:NUM_PARTITIONS];
    logic [IDX_W-1:0]      sel_chain  [0:NUM_PARTITIONS];
    logic [SIZE_BITS-1:0]  free_chain [0:NUM_PARTITIONS];
    logic [SIZE_BITS-1:0]  cap_chain  [0:NUM_PARTITIONS];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= FIT_MODE_RST;
            in_use_reg   <= IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FIT_MODE: fit_mode_reg <= pwdata[1:0];
                REG_IN_USE:   in_use_reg   <= pwdata[INUSE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIT_MODE: prdata = 32'(fit_mode_reg);
            REG_IN_USE:   prdata = 32'(in_use_reg);
            default:      prdata = '0;
        endcase
    end

    // input handshake and word decode
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_amt   = SIZE_BITS'(s_tdata[PIDX_W +: AMT_W]);
    assign ld_en    = accept && (s_tuser[0] == CMD_LOAD);
    assign commit   = (state_reg == ST_PEND) && (!out_valid_reg || m_tready);

    // search word entering the row
    assign ctl_chain[0].valid = accept && (s_tuser[0] == CMD_ALLOC);
    assign ctl_chain[0].found = 1'b0;
    assign ctl_chain[0].mode  = fit_mode_reg;
    assign amt_chain[0]       = in_amt;
    assign sel_chain[0]       = '0;
    assign free_chain[0]      = '0;
    assign cap_chain[0]       = '0;

    // cell row
    for (genvar i = 0; i < NUM_PARTITIONS; i++)
    begin : g_cell
        fpfa_cell #(
            .IDX       (i),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .limit    (in_use_reg),
            .ld_en    (ld_en),
            .ld_idx   (s_tdata[PIDX_W-1:0]),
            .ld_amt   (in_amt),
            .cm_en    (commit && pend_found_reg),
            .cm_sel   (pend_sel_reg),
            .cm_amt   (pend_amt_reg),
            .ctl_in   (ctl_chain[i]),
            .amt_in   (amt_chain[i]),
            .sel_in   (sel_chain[i]),
            .free_in  (free_chain[i]),
            .cap_in   (cap_chain[i]),
            .ctl_out  (ctl_chain[i+1]),
            .amt_out  (amt_chain[i+1]),
            .sel_out  (sel_chain[i+1]),
            .free_out (free_chain[i+1]),
            .cap_out  (cap_chain[i+1])
        );
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctl_chain[0].valid) state_next = ST_SCAN;
            ST_SCAN: if (ctl_chain[NUM_PARTITIONS].valid) state_next = ST_PEND;
            ST_PEND: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // finished search word held until the output slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_found_reg <= 1'b0;
        end
        else if (ctl_chain[NUM_PARTITIONS].valid)
        begin
            pend_found_reg <= ctl_chain[NUM_PARTITIONS].found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_chain[NUM_PARTITIONS].valid)
        begin
            pend_sel_reg <= sel_chain[NUM_PARTITIONS];
            pend_amt_reg <= amt_chain[NUM_PARTITIONS];
            pend_cap_reg <= cap_chain[NUM_PARTITIONS];
        end
    end

    // result register and request count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            req_cnt_reg   <= '0;
        end
        else
        begin
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                req_cnt_reg   <= req_cnt_reg + REQNUM_W'(1);
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= {{(M_DATA_W - REQNUM_W - 1 - PIDX_W - AMT_W){1'b0}},
                             pend_found_reg ? AMT_W'(pend_cap_reg) : AMT_W'(0),
                             pend_found_reg ? PIDX_W'(pend_sel_reg) : PIDX_W'(0),
                             pend_found_reg,
                             req_cnt_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : fixed_partition_fit_allocator

`default_nettype wire
